FILE: rtl/fskm_pkg.sv
`default_nettype none

package fskm_pkg;

  localparam int unsigned SamplesDef    = 16;
  localparam int unsigned CyclesZeroDef = 5;
  localparam int unsigned CyclesOneDef  = 10;
  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned DacW   = 12;
  localparam int unsigned RegW   = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DacW-1:0] DAC_MID = 12'd2047;

  localparam logic [RegW-1:0] HOLD_ZERO_RST = 16'd150;
  localparam logic [RegW-1:0] HOLD_ONE_RST  = 16'd75;
  localparam logic [RegW-1:0] GAP_ZERO_RST  = 16'd5250;
  localparam logic [RegW-1:0] GAP_ONE_RST   = 16'd1250;
  localparam logic [RegW-1:0] TAIL_TIME_RST = 16'd30000;

  localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HOLD_ZERO = 3'd0,
    REG_HOLD_ONE  = 3'd1,
    REG_GAP_ZERO  = 3'd2,
    REG_GAP_ONE   = 3'd3,
    REG_TAIL_TIME = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PLAY = 2'd1,
    PH_GAP  = 2'd2,
    PH_TAIL = 2'd3
  } phase_e;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_LOAD = 1'b1
  } req_kind_e;

  typedef struct packed {
    logic             opcode;
    logic [ByteW-1:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [DacW-1:0] dac_value;
    logic            busy_res;
    logic            done_res;
  } out_t;

  typedef struct packed {
    req_kind_e        kind;
    logic [ByteW-1:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [RegW-1:0] hold_zero;
    logic [RegW-1:0] hold_one;
    logic [RegW-1:0] gap_zero;
    logic [RegW-1:0] gap_one;
    logic [RegW-1:0] tail_time;
  } cfg_t;

  // quarter-wave sine in q30, taylor series to the 15th power
  function automatic logic [63:0] sine_q30(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    if (r == 64'd0) return 64'd0;
    if (r >= Q30_ONE) return Q30_ONE;
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      prod = (term * x2) >> 30;
      case (k)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        default: term = prod / 64'd210;
      endcase
      if ((k & 1) != 0) begin
        sum = (term > sum) ? 64'd0 : sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum > Q30_ONE) ? Q30_ONE : sum;
  endfunction

  // dac code for a turn fraction in q32
  function automatic logic [DacW-1:0] sine_code(input logic [63:0] turn);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] v;
    quad = turn[31:30];
    r    = {34'd0, turn[29:0]};
    if (quad[0]) r = Q30_ONE - r;
    s = sine_q30(r);
    if (!quad[1]) begin
      v = (64'd4095 * Q30_ONE + 64'd4095 * s) >> 31;
    end else begin
      v = (64'd4095 * Q30_ONE - 64'd4095 * s) >> 31;
    end
    return v[DacW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fskm_in_if.sv
`default_nettype none

interface fskm_in_if
  import fskm_pkg::*;
();
  logic valid;
  logic ready;
  in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/fskm_out_if.sv
`default_nettype none

interface fskm_out_if
  import fskm_pkg::*;
();
  logic valid;
  logic ready;
  out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/fskm_front.sv
`default_nettype none

module fskm_front
  import fskm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fskm_in_if.sink   in_i,
  input  wire logic q_ready_i,
  output logic      push_o,
  output req_t      req_o
);

  logic valid_q;
  logic valid_d;
  req_t req_q;
  req_t req_d;

  // classify: tick request or load request
  always_comb begin
    in_i.ready = !valid_q || q_ready_i;
    push_o     = valid_q && q_ready_i;
    req_o      = req_q;
    valid_d    = valid_q;
    req_d      = req_q;
    if (push_o) valid_d = 1'b0;
    if (in_i.valid && in_i.ready) begin
      valid_d         = 1'b1;
      req_d.kind      = in_i.payload.opcode ? REQ_LOAD : REQ_TICK;
      req_d.data_byte = in_i.payload.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

endmodule

`default_nettype wire

FILE: rtl/fskm_queue.sv
`default_nettype none

module fskm_queue
  import fskm_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  req_t      req_i,
  output logic      ready_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output req_t      req_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  req_t            slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW-1:0] rd_ptr_d;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;

  always_comb begin
    ready_o  = count_q != CntW'(DEPTH);
    valid_o  = count_q != '0;
    req_o    = slots_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fskm_back.sv
`default_nettype none

module fskm_back
  import fskm_pkg::*;
#(
  parameter int unsigned SAMPLES     = SamplesDef,
  parameter int unsigned CYCLES_ZERO = CyclesZeroDef,
  parameter int unsigned CYCLES_ONE  = CyclesOneDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic q_valid_i,
  input  req_t      q_req_i,
  output logic      pop_o,
  fskm_out_if.source out_o
);

  localparam int unsigned PosW = $clog2(SAMPLES);
  localparam logic [PosW-1:0] PosLast  = PosW'(SAMPLES - 1);
  localparam logic [3:0]      CycZero  = 4'(CYCLES_ZERO);
  localparam logic [3:0]      CycOne   = 4'(CYCLES_ONE);

  logic [DacW-1:0] sine_tab [SAMPLES];

  for (genvar gi = 0; gi < SAMPLES; gi++) begin : g_tab
    localparam logic [63:0] Turn = (64'(gi) << 32) / 64'(SAMPLES);
    assign sine_tab[gi] = sine_code(Turn);
  end

  phase_e          phase_q, phase_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [2:0]      bitn_q, bitn_d;
  logic [3:0]      cyc_q, cyc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [RegW-1:0] time_q, time_d;
  logic [DacW-1:0] dac_q, dac_d;
  logic            done_d;

  logic            start_bit;
  logic            end_gap;
  logic            start_samp;
  logic [RegW-1:0] time_dec;
  logic [RegW-1:0] gap_len;
  logic [RegW-1:0] hold_raw;

  logic            out_valid_q;
  out_t            out_q;

  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    bitn_d     = bitn_q;
    cyc_d      = cyc_q;
    pos_d      = pos_q;
    time_d     = time_q;
    dac_d      = dac_q;
    done_d     = 1'b0;
    start_bit  = 1'b0;
    end_gap    = 1'b0;
    start_samp = 1'b0;
    time_dec   = time_q - {15'd0, time_q != '0};
    gap_len    = shift_q[0] ? cfg_i.gap_one : cfg_i.gap_zero;
    pop_o      = q_valid_i && (!out_valid_q || out_o.ready);

    if (pop_o) begin
      if (q_req_i.kind == REQ_LOAD) begin
        if (phase_q == PH_IDLE) begin
          shift_d   = q_req_i.data_byte;
          bitn_d    = '0;
          start_bit = 1'b1;
        end
      end else if (phase_q != PH_IDLE) begin
        time_d = time_dec;
        if (time_dec == '0) begin
          unique case (phase_q)
            PH_PLAY: begin
              if (pos_q != '0) begin
                pos_d      = pos_q - 1'b1;
                start_samp = 1'b1;
              end else if (cyc_q > 4'd1) begin
                cyc_d      = cyc_q - 1'b1;
                pos_d      = PosLast;
                start_samp = 1'b1;
              end else begin
                cyc_d   = '0;
                time_d  = gap_len;
                phase_d = PH_GAP;
                end_gap = gap_len == '0;
              end
            end
            PH_GAP: begin
              end_gap = 1'b1;
            end
            PH_TAIL: begin
              phase_d = PH_IDLE;
              done_d  = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end

    // bit finished: next bit, or midscale and tail after the last one (straight to idle if the tail time is zero)
    if (end_gap) begin
      shift_d = shift_q >> 1;
      if (bitn_q == 3'd7) begin
        bitn_d = '0;
        dac_d  = DAC_MID;
        time_d = cfg_i.tail_time;
        if (cfg_i.tail_time == '0) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end else begin
          phase_d = PH_TAIL;
        end
      end else begin
        bitn_d    = bitn_q + 1'b1;
        start_bit = 1'b1;
      end
    end

    if (start_bit) begin
      cyc_d      = shift_d[0] ? CycOne : CycZero;
      pos_d      = PosLast;
      phase_d    = PH_PLAY;
      start_samp = 1'b1;
    end

    hold_raw = shift_d[0] ? cfg_i.hold_one : cfg_i.hold_zero;
    if (start_samp) begin
      dac_d  = sine_tab[pos_d];
      time_d = (hold_raw == '0) ? 16'd1 : hold_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      shift_q <= '0;
      bitn_q  <= '0;
      cyc_q   <= '0;
      pos_q   <= '0;
      time_q  <= '0;
      dac_q   <= DAC_MID;
    end else begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      bitn_q  <= bitn_d;
      cyc_q   <= cyc_d;
      pos_q   <= pos_d;
      time_q  <= time_d;
      dac_q   <= dac_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.dac_value <= dac_d;
      out_q.busy_res  <= phase_d != PH_IDLE;
      out_q.done_res  <= done_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

`default_nettype wire

FILE: rtl/fsk_sine_byte_modulator.sv
// a request passes the front register, the queue and the output register before its result is valid
// throughput: one request per cycle while the output is not stalled; the bit sequencer updates on each pop
// a queue (two entries by default) separates request intake from the sequencer
// reset: asynchronous, active low; sample register at midscale 2047, idle, registers at defaults
`default_nettype none

module fsk_sine_byte_modulator
  import fskm_pkg::*;
#(
  parameter int unsigned SAMPLES     = SamplesDef,
  parameter int unsigned CYCLES_ZERO = CyclesZeroDef,
  parameter int unsigned CYCLES_ONE  = CyclesOneDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [RegW-1:0]    cfg_data_i,
  fskm_in_if.sink                 in_i,
  fskm_out_if.source              out_o
);

  cfg_t cfg_q;
  logic push;
  req_t push_req;
  logic q_ready;
  logic q_valid;
  req_t q_req;
  logic pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_zero <= HOLD_ZERO_RST;
      cfg_q.hold_one  <= HOLD_ONE_RST;
      cfg_q.gap_zero  <= GAP_ZERO_RST;
      cfg_q.gap_one   <= GAP_ONE_RST;
      cfg_q.tail_time <= TAIL_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HOLD_ZERO: cfg_q.hold_zero <= cfg_data_i;
        REG_HOLD_ONE:  cfg_q.hold_one  <= cfg_data_i;
        REG_GAP_ZERO:  cfg_q.gap_zero  <= cfg_data_i;
        REG_GAP_ONE:   cfg_q.gap_one   <= cfg_data_i;
        REG_TAIL_TIME: cfg_q.tail_time <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fskm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .req_o     (push_req)
  );

  fskm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .req_o   (q_req)
  );

  fskm_back #(
    .SAMPLES     (SAMPLES),
    .CYCLES_ZERO (CYCLES_ZERO),
    .CYCLES_ONE  (CYCLES_ONE)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_req_i   (q_req),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/fskm_checker.sv
`default_nettype none

module fskm_checker
  import fskm_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire logic [DacW-1:0] dac_value_i,
  input wire logic            busy_i,
  input wire logic            done_i
);

  // idle output always sits at midscale
  a_idle_mid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_i |-> dac_value_i == DAC_MID)
    else $error("idle result not at midscale");

  // finishing request reports not busy
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_i |-> !busy_i)
    else $error("done while busy");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(dac_value_i)
      && $stable(busy_i) && $stable(done_i))
    else $error("stalled result changed");

endmodule

bind fsk_sine_byte_modulator fskm_checker u_fskm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .dac_value_i (out_o.payload.dac_value),
  .busy_i      (out_o.payload.busy_res),
  .done_i      (out_o.payload.done_res)
);

`default_nettype wire
